/* rtl/gpr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the pyramid reduce block.
// No dependencies; the register file, line store, divider and top level import this package.
package gpr_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int PIXEL_BITS = 16;
  localparam int LINE_COUNT = 4;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LINE_W     = $clog2(LINE_COUNT);
  localparam int ADDR_W     = COL_W + LINE_W;
  localparam int ROW_W      = 16;
  localparam int VS_W       = 21;  // one column sum: up to 20 * max pixel
  localparam int S_W        = 25;  // full 5x5 sum: up to 400 * max pixel
  localparam int WT_W       = 5;   // weight of a clipped 1-D window
  localparam int TOT_W      = 9;   // product of two window weights

  typedef struct packed {
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    logic             row_phase;
    logic             col_phase;
    logic             restart;
  } cfg_t;

  // Centres whose clipped window ends at the current position, given as
  // distance back from that position, in ascending centre order.
  typedef struct packed {
    logic [1:0] n;
    logic [1:0] e0;
    logic [1:0] e1;
  } cent_t;

  function automatic logic [3:0] tap_of(logic [2:0] idx);
    logic [3:0] t;
    case (idx)
      3'd0:    t = 4'd1;
      3'd1:    t = 4'd5;
      3'd2:    t = 4'd8;
      3'd3:    t = 4'd5;
      3'd4:    t = 4'd1;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

  function automatic cent_t centres(logic [15:0] p, logic [15:0] last, logic phase);
    cent_t      res;
    logic [1:0] n;
    res = '0;
    n   = 2'd0;
    if (p >= 16'd2 && p[0] == phase) begin
      res.e0 = 2'd2;
      n      = 2'd1;
    end
    if (p == last) begin
      if (p >= 16'd1 && p[0] != phase) begin
        if (n == 2'd0) res.e0 = 2'd1;
        else res.e1 = 2'd1;
        n = n + 2'd1;
      end
      if (p[0] == phase && n < 2'd2) begin
        if (n == 2'd0) res.e0 = 2'd0;
        else res.e1 = 2'd0;
        n = n + 2'd1;
      end
    end
    res.n = n;
    return res;
  endfunction

endpackage

/* rtl/gpr_cfg_regs.sv */
`timescale 1ns / 1ps
// APB register file of the pyramid reduce block: frame size and phases.
// Depends on gpr_pkg.
module gpr_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gpr_pkg::cfg_t      cfg_o
);
  import gpr_pkg::*;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RPHASE = 2'd2;
  localparam logic [1:0] REG_CPHASE = 2'd3;

  logic [11:0] width_q;
  logic [15:0] height_q;
  logic        rph_q, cph_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 12'd640;
      height_q  <= 16'd480;
      rph_q     <= 1'b0;
      cph_q     <= 1'b0;
    end else begin
      if (wr_en) begin
        case (paddr[3:2])
          REG_WIDTH:  width_q  <= pwdata[11:0];
          REG_HEIGHT: height_q <= pwdata[15:0];
          REG_RPHASE: rph_q    <= pwdata[0];
          REG_CPHASE: cph_q    <= pwdata[0];
          default:    rph_q    <= rph_q;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {20'd0, width_q};
      REG_HEIGHT: prdata = {16'd0, height_q};
      REG_RPHASE: prdata = {31'd0, rph_q};
      REG_CPHASE: prdata = {31'd0, cph_q};
      default:    prdata = 32'd0;
    endcase
  end

  // A width of zero counts as one column; widths above the line length saturate.
  // The frame restarts at the same edge as the register write.
  always_comb begin
    if (width_q == 12'd0) cfg_o.w_last = '0;
    else if ({1'b0, width_q} > 13'(MAX_WIDTH)) cfg_o.w_last = COL_W'(MAX_WIDTH - 1);
    else cfg_o.w_last = COL_W'(width_q - 12'd1);
    cfg_o.h_last    = (height_q == 16'd0) ? 16'd0 : height_q - 16'd1;
    cfg_o.row_phase = rph_q;
    cfg_o.col_phase = cph_q;
    cfg_o.restart   = wr_en;
  end

endmodule

/* rtl/gpr_line_mem.sv */
`timescale 1ns / 1ps
// Line store: four image lines in one single-port synchronous memory.
// Depends on gpr_pkg.
module gpr_line_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [gpr_pkg::ADDR_W-1:0]     addr_i,
  input  logic [gpr_pkg::PIXEL_BITS-1:0] wdata_i,
  output logic [gpr_pkg::PIXEL_BITS-1:0] rdata_o
);
  import gpr_pkg::*;

  logic [PIXEL_BITS-1:0] mem [LINE_COUNT*MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    else rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gpr_divider.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the normalising division.
// Depends on gpr_pkg.
module gpr_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gpr_pkg::S_W-1:0]    num_i,
  input  logic [gpr_pkg::TOT_W-1:0]  den_i,
  output logic                       done_o,
  output logic [15:0]                quot_o
);
  import gpr_pkg::*;

  localparam int CNT_W = $clog2(S_W + 1);

  logic [S_W-1:0]   num_q;
  logic [TOT_W-1:0] den_q, rem_q, rem_d;
  logic [TOT_W:0]   rem_sh;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, qbit;

  always_comb begin
    rem_sh = {rem_q, num_q[S_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    rem_d  = qbit ? TOT_W'(rem_sh - {1'b0, den_q}) : rem_sh[TOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(S_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift in behind the numerator bits as they are used.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[S_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q[15:0];

endmodule

/* rtl/gaussian_pyramid_reduce_unit.sv */
`timescale 1ns / 1ps
// Gaussian pyramid reduce, one level: 5x5 separable kernel 1,5,8,5,1 over 20,
// evaluated at every second row and column, windows clipped at the borders
// and normalised by the weight that remains, rounded to nearest.
// Channels: pixels enter on s_axis in raster order; results leave on m_axis
// with pixel, output row and column in tdata, run_last on tlast and
// frame_done on tuser. Frame size and phases are set over the APB port; any
// write restarts the frame at row 0, column 0.
// Flow: one pixel at a time. Every pixel passes through accept, four
// line-store reads on the single memory port, drain and write-back. Each of
// its results, at most four, then takes five column-tap steps, a setup
// state, 25 steps of the bit-serial divider, the capture of the quotient
// and the output register, where it waits while m_axis_tready is low.
// A result holds on m_axis until taken; no new pixel is accepted meanwhile.
// Reset returns the counters to the frame start and the registers to
// 640 by 480 with both phases zero. The line store needs no clearing pass:
// only lines written earlier in the frame are used.
// Depends on gpr_pkg, gpr_cfg_regs, gpr_line_mem and gpr_divider.
module gaussian_pyramid_reduce_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pixel_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] pixel_out, [30:16] out_row, [40:31] out_col
  output logic        m_axis_tuser,   // frame_done
  output logic        m_axis_tlast    // run_last
);
  import gpr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_DRAIN = 8'b0000_0100,
    S_WB    = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_PREP  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  cfg_t   cfg;

  logic [ROW_W-1:0]      row_cnt_q, cur_r_q;
  logic [COL_W-1:0]      col_cnt_q, cur_c_q;
  logic [PIXEL_BITS-1:0] pix_q;
  cent_t                 ycen, xcen, ycen_q, xcen_q;
  logic                  frame_end_q;
  logic [1:0]            e_q [2];
  logic [VS_W-1:0]       vs_q [2];
  logic [WT_W-1:0]       vw_q [2];
  logic [VS_W-1:0]       cs_q [2][5];
  logic [2:0]            rd_i_q, acc_i_q, sum_i_q;
  logic                  acc_vld_q;
  logic                  kk_q, jj_q;
  logic [1:0]            f_cur;
  logic [S_W-1:0]        s_q;
  logic [WT_W-1:0]       hw_q;
  logic [TOT_W-1:0]      tot;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [PIXEL_BITS-1:0] mem_rdata;
  logic                  div_start, div_done;
  logic [15:0]           div_quot;
  logic                  in_acc, out_acc, last_res;
  logic [15:0]           out_pix_q;
  logic [14:0]           out_row_q;
  logic [9:0]            out_col_q;
  logic                  out_last_q, out_done_q;
  logic [ROW_W-1:0]      y_cur;
  logic [COL_W-1:0]      x_cur;
  logic [3:0]            rtmp [2];
  logic [3:0]            ctmp;
  logic [3:0]            ctap;

  gpr_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  gpr_line_mem u_mem (
    .clk_i,
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (pix_q),
    .rdata_o (mem_rdata)
  );

  gpr_divider u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (s_q + S_W'(tot >> 1)),
    .den_i   (tot),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {7'd0, out_col_q, out_row_q, out_pix_q};
  assign m_axis_tuser  = out_done_q;
  assign m_axis_tlast  = out_last_q;

  assign ycen = centres(row_cnt_q, cfg.h_last, cfg.row_phase);
  assign xcen = centres({{(16-COL_W){1'b0}}, col_cnt_q},
                        {{(16-COL_W){1'b0}}, cfg.w_last}, cfg.col_phase);

  // Line n of the frame lives in line slot n mod 4; older rows are read
  // before the current pixel overwrites the slot of the row four back.
  assign mem_we   = (state_q == S_WB);
  assign mem_addr = mem_we ? {cur_r_q[LINE_W-1:0], cur_c_q}
                           : {LINE_W'(cur_r_q[LINE_W-1:0] - rd_i_q[LINE_W-1:0]), cur_c_q};

  assign div_start = (state_q == S_PREP);
  assign tot       = TOT_W'(vw_q[kk_q] * hw_q);
  assign last_res  = ({1'b0, kk_q} == ycen_q.n - 2'd1) && ({1'b0, jj_q} == xcen_q.n - 2'd1);
  assign f_cur     = jj_q ? xcen_q.e1 : xcen_q.e0;
  assign y_cur     = cur_r_q - ROW_W'(kk_q ? ycen_q.e1 : ycen_q.e0);
  assign x_cur     = cur_c_q - COL_W'(f_cur);
  assign ctmp      = {2'b0, f_cur} + 4'd2 - {1'b0, sum_i_q};
  assign ctap      = (!ctmp[3] && {{(COL_W-3){1'b0}}, sum_i_q} <= cur_c_q)
                     ? tap_of(ctmp[2:0]) : 4'd0;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rtmp[k] = {2'b0, e_q[k]} + 4'd2 - {1'b0, acc_i_q};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_READ;
      S_READ:  if (rd_i_q == 3'd4) state_d = S_DRAIN;
      S_DRAIN: state_d = S_WB;
      S_WB:    state_d = (ycen_q.n == 2'd0 || xcen_q.n == 2'd0) ? S_IDLE : S_SUM;
      S_SUM:   if (sum_i_q == 3'd4) state_d = S_PREP;
      S_PREP:  state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (out_acc) state_d = last_res ? S_IDLE : S_SUM;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      acc_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_vld_q <= (state_q == S_READ);
      if (cfg.restart) begin
        row_cnt_q <= '0;
        col_cnt_q <= '0;
      end else if (state_q == S_WB) begin
        if (cur_c_q == cfg.w_last) begin
          col_cnt_q <= '0;
          row_cnt_q <= (cur_r_q == cfg.h_last) ? '0 : cur_r_q + 1'b1;
        end else begin
          col_cnt_q <= cur_c_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q       <= s_axis_tdata[PIXEL_BITS-1:0];
      cur_r_q     <= row_cnt_q;
      cur_c_q     <= col_cnt_q;
      ycen_q      <= ycen;
      xcen_q      <= xcen;
      frame_end_q <= (row_cnt_q == cfg.h_last) && (col_cnt_q == cfg.w_last);
      e_q[0]      <= ycen.e0;
      e_q[1]      <= ycen.e1;
      rd_i_q      <= 3'd1;
      for (int k = 0; k < 2; k++) begin
        if (2'(k) < ycen.n) begin
          vs_q[k] <= VS_W'(tap_of({1'b0, (k == 0 ? ycen.e0 : ycen.e1)} + 3'd2))
                     * VS_W'(s_axis_tdata[PIXEL_BITS-1:0]);
          vw_q[k] <= WT_W'(tap_of({1'b0, (k == 0 ? ycen.e0 : ycen.e1)} + 3'd2));
        end else begin
          vs_q[k] <= '0;
          vw_q[k] <= '0;
        end
      end
    end else begin
      if (state_q == S_READ) rd_i_q <= rd_i_q + 3'd1;
      if (acc_vld_q) begin
        for (int k = 0; k < 2; k++) begin
          if (2'(k) < ycen_q.n && !rtmp[k][3]
              && {{(ROW_W-3){1'b0}}, acc_i_q} <= cur_r_q) begin
            vs_q[k] <= vs_q[k] + VS_W'(tap_of(rtmp[k][2:0])) * VS_W'(mem_rdata);
            vw_q[k] <= vw_q[k] + WT_W'(tap_of(rtmp[k][2:0]));
          end
        end
      end
    end
    acc_i_q <= rd_i_q;

    if (state_q == S_WB) begin
      for (int k = 0; k < 2; k++) begin
        for (int j = 0; j < 4; j++) cs_q[k][j] <= cs_q[k][j+1];
        cs_q[k][4] <= vs_q[k];
      end
      kk_q    <= 1'b0;
      jj_q    <= 1'b0;
      sum_i_q <= 3'd0;
      s_q     <= '0;
      hw_q    <= '0;
    end

    if (state_q == S_SUM) begin
      s_q     <= s_q + S_W'(ctap) * S_W'(cs_q[kk_q][3'd4 - sum_i_q]);
      hw_q    <= hw_q + WT_W'(ctap);
      sum_i_q <= sum_i_q + 3'd1;
    end

    if (state_q == S_DIV && div_done) begin
      out_pix_q  <= div_quot;
      out_row_q  <= y_cur[15:1];
      out_col_q  <= x_cur[10:1];
      out_last_q <= last_res;
      out_done_q <= last_res & frame_end_q;
    end

    if (state_q == S_OUT && out_acc && !last_res) begin
      sum_i_q <= 3'd0;
      s_q     <= '0;
      hw_q    <= '0;
      if ({1'b0, jj_q} == xcen_q.n - 2'd1) begin
        jj_q <= 1'b0;
        kk_q <= 1'b1;
      end else begin
        jj_q <= 1'b1;
      end
    end
  end

endmodule

/* rtl/gpr_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the pyramid reduce block, bound to the top level.
// Depends on gaussian_pyramid_reduce_unit's port list only.
module gpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A result on hold keeps its payload until the transaction completes.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("result changed while stalled");

  // The final result of a frame is always the last one of its pixel.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame_done without run_last");

  // One pixel at a time: no input is taken while a result is offered.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after a transaction");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind gaussian_pyramid_reduce_unit gpr_checker u_gpr_checker (.*);

/* test/gaussian_pyramid_reduce_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for gaussian_pyramid_reduce_unit: streams frames of
// random and directed pixels, predicts every decimated result and checks them.
// Depends on the RTL top level only; no files are read.
module gaussian_pyramid_reduce_unit_tb;

  localparam int unsigned REG_WIDTH  = 0;
  localparam int unsigned REG_HEIGHT = 1;
  localparam int unsigned REG_RPHASE = 2;
  localparam int unsigned REG_CPHASE = 3;
  localparam int unsigned LINE_MAX   = 2048;
  localparam int unsigned DRAIN_WAIT = 250;

  typedef struct {
    logic [15:0] pixel;
    logic [14:0] row;
    logic [9:0]  col;
    logic        done;
    logic        last;
  } reduced_px_t;

  class reduce_scoreboard;
    logic [15:0] lines [4][LINE_MAX];
    longint unsigned col_sums [2][5];
    int unsigned cur_row, cur_col;
    int unsigned width_reg, height_reg, rphase, cphase;
    reduced_px_t pending_px[$];
    int unsigned errors;

    function void reset_state();
      cur_row = 0; cur_col = 0;
      width_reg = 640; height_reg = 480; rphase = 0; cphase = 0;
      foreach (col_sums[k, j]) col_sums[k][j] = 0;
      pending_px.delete();
      errors = 0;
    endfunction

    function void write_reg(int unsigned idx, int unsigned val);
      case (idx)
        REG_WIDTH:  width_reg  = val & 12'hFFF;
        REG_HEIGHT: height_reg = val & 16'hFFFF;
        REG_RPHASE: rphase     = val & 1;
        REG_CPHASE: cphase     = val & 1;
        default: return;
      endcase
      cur_row = 0; cur_col = 0;
    endfunction

    function int unsigned tap(int unsigned i);
      case (i)
        0, 4:    return 1;
        1, 3:    return 5;
        default: return 8;
      endcase
    endfunction

    // Centres whose clipped window closes at position p, in ascending order.
    function int unsigned centres_at(int unsigned p, int unsigned len, int unsigned ph,
                                     output int unsigned lst[2]);
      int unsigned n;
      n = 0; lst[0] = 0; lst[1] = 0;
      if (p >= 2 && ((p - 2) & 1) == ph) begin lst[n] = p - 2; n++; end
      if (p == len - 1) begin
        if (p >= 1 && ((p - 1) & 1) == ph) begin lst[n] = p - 1; n++; end
        if ((p & 1) == ph && n < 2) begin lst[n] = p; n++; end
      end
      return n;
    endfunction

    function int unsigned lo_of(int unsigned c);
      return c >= 2 ? c - 2 : 0;
    endfunction

    function int unsigned hi_of(int unsigned c, int unsigned len);
      return c + 2 > len - 1 ? len - 1 : c + 2;
    endfunction

    function void note_pixel(logic [15:0] pix);
      int unsigned w, h, r, c, ny, nx, cnt;
      int unsigned ys[2], xs[2];
      longint unsigned vs, vw, s, hw, tot;
      reduced_px_t res;
      w = width_reg == 0 ? 1 : (width_reg > LINE_MAX ? LINE_MAX : width_reg);
      h = height_reg == 0 ? 1 : height_reg;
      r = cur_row; c = cur_col;
      ny = centres_at(r, h, rphase, ys);
      for (int k = 0; k < 2; k++) begin
        vs = 0;
        if (k < ny)
          for (int unsigned n = lo_of(ys[k]); n <= hi_of(ys[k], h); n++)
            vs += tap(n + 2 - ys[k]) * ((n == r) ? pix : lines[n % 4][c]);
        for (int j = 0; j < 4; j++) col_sums[k][j] = col_sums[k][j + 1];
        col_sums[k][4] = vs;
      end
      lines[r % 4][c] = pix;
      nx = centres_at(c, w, cphase, xs);
      cnt = 0;
      for (int k = 0; k < ny; k++) begin
        vw = 0;
        for (int unsigned n = lo_of(ys[k]); n <= hi_of(ys[k], h); n++)
          vw += tap(n + 2 - ys[k]);
        for (int j = 0; j < nx; j++) begin
          s = 0; hw = 0;
          for (int unsigned m = lo_of(xs[j]); m <= hi_of(xs[j], w); m++) begin
            s  += tap(m + 2 - xs[j]) * col_sums[k][(m + 4 - c) % 5];
            hw += tap(m + 2 - xs[j]);
          end
          tot = vw * hw;
          res.pixel = 16'((s + tot / 2) / tot);
          res.row   = 15'(ys[k] >> 1);
          res.col   = 10'(xs[j] >> 1);
          res.done  = 1'b0;
          res.last  = 1'b0;
          pending_px = {pending_px, res};
          cnt++;
        end
      end
      if (cnt > 0) begin
        pending_px[$].last = 1'b1;
        if (r == h - 1 && c == w - 1) pending_px[$].done = 1'b1;
      end
      if (c + 1 >= w) begin
        cur_col = 0;
        cur_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        cur_col = c + 1;
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t ns: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [47:0] data, logic done, logic last);
      reduced_px_t e;
      if (pending_px.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      e = pending_px.pop_front();
      if (data[15:0] !== e.pixel)
        report($sformatf("pixel_out %h, wanted %h", data[15:0], e.pixel));
      if (data[30:16] !== e.row)
        report($sformatf("out_row %0d, wanted %0d", data[30:16], e.row));
      if (data[40:31] !== e.col)
        report($sformatf("out_col %0d, wanted %0d", data[40:31], e.col));
      if (done !== e.done) report($sformatf("frame_done %b, wanted %b", done, e.done));
      if (last !== e.last) report($sformatf("run_last %b, wanted %b", last, e.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;   // [15:0] pixel_out, [30:16] out_row, [40:31] out_col
  logic        m_axis_tuser;   // frame_done
  logic        m_axis_tlast;   // run_last

  reduce_scoreboard sb;
  int unsigned ready_pct = 100;

  gaussian_pyramid_reduce_unit uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
    m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  task automatic wait_drained();
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic apb_write(int unsigned idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned rp, int unsigned cp);
    wait_drained();
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_RPHASE, rp);
    apb_write(REG_CPHASE, cp);
    ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(30, 95);
  endtask

  // Sends n pixels in bursts; an empty pattern selects random pixel values.
  task automatic send_pixels(int unsigned n, logic [15:0] pattern[$] = {});
    int unsigned burst;
    burst = $urandom_range(1, 12);
    for (int unsigned i = 0; i < n; i++) begin
      s_axis_tdata  <= (pattern.size() != 0) ? pattern[i % pattern.size()]
                                             : 16'($urandom());
      s_axis_tvalid <= 1'b1;
      do @(posedge clk_i); while (!s_axis_tready);
      if (--burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("gaussian_pyramid_reduce_unit regression: fail");
    $finish;
  end

  initial begin
    int unsigned w, h, sent;
    sb = new();
    sb.reset_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme pixel values on a small frame, both phases zero.
    set_frame(4, 4, 0, 0);
    send_pixels(16, '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'hFFFF});
    // Single row with odd row parity: nothing comes out.
    set_frame(3, 1, 1, 0);
    send_pixels(3, '{16'hFFFF});
    // Zero sizes behave as one pixel.
    set_frame(0, 0, 0, 0);
    send_pixels(1, '{16'h8001});
    set_frame(1, 1, 1, 1);
    send_pixels(1);
    set_frame(2, 3, 1, 1);
    send_pixels(6, '{16'hFFFF, 16'h0001});

    // Oversized width: the start of a saturated row, cut off by the next write.
    set_frame(4095, 1, 0, 0);
    send_pixels(16);
    // Tallest frame: only the first rows are sent, a later write restarts it.
    set_frame(5, 65535, 0, 1);
    send_pixels(13);

    sent = 0;
    while (sent < 100) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 7);
      set_frame(w, h, $urandom_range(0, 1), $urandom_range(0, 1));
      send_pixels(w * h);
      sent += w * h;
    end

    wait_drained();
    if (sb.errors == 0) $display("gaussian_pyramid_reduce_unit regression: pass");
    else $display("gaussian_pyramid_reduce_unit regression: fail");
    $finish;
  end

endmodule
